@@ rtl/fsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_pkg: shared types and constants of the segment allocator
// Opcodes, status codes, cell commands and the control groups that pass
// between the sequencer and the row of segment cells.
// ----------------------------------------------------------------------------
package fsa_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int ADDR_BITS_DEF    = 16;

   localparam int OP_W     = 2;
   localparam int SIZE_W   = 16;
   localparam int BADDR_W  = 16;
   localparam int STATUS_W = 2;
   localparam int GRANT_W  = 16;
   localparam int COUNT_W  = 7;
   localparam int HDR_W    = 8;
   localparam int POOL_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;

   // Rounded request plus header never exceeds 2^16 + 255.
   localparam int NEED_W = 18;

   localparam logic [POOL_W-1:0] RESET_POOL   = 16'hFFFF;
   localparam logic [HDR_W-1:0]  RESET_HEADER = 8'd32;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd127;

   localparam logic [CSR_IDX_W-1:0] CSR_FIT_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER   = 2'd2;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_COUNT = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NO_MEMORY = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FREED     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CMD_NONE   = 3'd0,
      CMD_INIT   = 3'd1,
      CMD_WRITE  = 3'd2,
      CMD_INSERT = 3'd3,
      CMD_REMOVE = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         used;
   } cmd_ctl_type;

   typedef struct packed {
      logic valid;
      logic found;
      logic used_i;
      logic has_prev;
      logic prev_used;
      logic has_next;
      logic next_used;
   } tok_ctl_type;

endpackage

@@ rtl/fsa_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_cell: one entry of the segment table
// Holds start, length and used flag of one segment, shifts entries to and
// from its neighbors, and updates the search token as it passes through.
// ----------------------------------------------------------------------------
module fsa_cell #(
   parameter int INDEX     = 0,
   parameter int ADDR_BITS = 16,
   parameter int IW        = 6,
   parameter int TW        = 7,
   parameter int CW        = 18,
   parameter int CNT_W     = 7
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [TW-1:0]              total,
   input  fsa_pkg::op_type            op,
   input  logic                       fit_mode,
   input  logic [fsa_pkg::NEED_W-1:0] need,
   input  logic [fsa_pkg::SIZE_W-1:0] limit,
   input  logic [fsa_pkg::BADDR_W-1:0] baddr,
   input  fsa_pkg::cmd_ctl_type       cmd,
   input  logic [IW-1:0]              cmd_idx,
   input  logic [ADDR_BITS-1:0]       cmd_start,
   input  logic [ADDR_BITS-1:0]       cmd_len,
   input  logic [ADDR_BITS-1:0]       left_start,
   input  logic [ADDR_BITS-1:0]       left_len,
   input  logic                       left_used,
   input  logic [ADDR_BITS-1:0]       right_start,
   input  logic [ADDR_BITS-1:0]       right_len,
   input  logic                       right_used,
   output logic [ADDR_BITS-1:0]       seg_start,
   output logic [ADDR_BITS-1:0]       seg_len,
   output logic                       seg_used,
   input  fsa_pkg::tok_ctl_type       tok_in,
   input  logic [IW-1:0]              tok_in_idx,
   input  logic [ADDR_BITS-1:0]       tok_in_len,
   input  logic [ADDR_BITS-1:0]       tok_in_start,
   input  logic [ADDR_BITS-1:0]       tok_in_prev_len,
   input  logic [ADDR_BITS-1:0]       tok_in_next_len,
   input  logic [CNT_W-1:0]           tok_in_cnt,
   output fsa_pkg::tok_ctl_type       tok_out,
   output logic [IW-1:0]              tok_out_idx,
   output logic [ADDR_BITS-1:0]       tok_out_len,
   output logic [ADDR_BITS-1:0]       tok_out_start,
   output logic [ADDR_BITS-1:0]       tok_out_prev_len,
   output logic [ADDR_BITS-1:0]       tok_out_next_len,
   output logic [CNT_W-1:0]           tok_out_cnt
);
   import fsa_pkg::*;

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
   localparam logic [TW-1:0] MY_POS = TW'(INDEX);
   localparam logic [TW-1:0] NX_POS = TW'(INDEX + 1);

   logic [ADDR_BITS-1:0] start_ff, start_in;
   logic [ADDR_BITS-1:0] len_ff, len_in;
   logic                 used_ff, used_in;

   tok_ctl_type          tctl_ff, tctl_in;
   logic [IW-1:0]        tidx_ff, tidx_in;
   logic [ADDR_BITS-1:0] tlen_ff, tlen_in;
   logic [ADDR_BITS-1:0] tstart_ff, tstart_in;
   logic [ADDR_BITS-1:0] tprev_ff, tprev_in;
   logic [ADDR_BITS-1:0] tnext_ff, tnext_in;
   logic [CNT_W-1:0]     tcnt_ff, tcnt_in;

   logic          live;
   logic [CW-1:0] len_x;
   logic [CW-1:0] blen_x;
   logic          fits;
   logic          better;

   assign live   = MY_POS < total;
   assign len_x  = CW'(len_ff);
   assign blen_x = CW'(tok_in_len);
   assign fits   = live && !used_ff && (len_x >= CW'(need));
   assign better = fit_mode ? (len_x > blen_x) : (len_x < blen_x);

   // Table entry update from the broadcast command.
   always_comb begin
      start_in = start_ff;
      len_in   = len_ff;
      used_in  = used_ff;
      unique case (cmd.kind)
         CMD_INIT: begin
            start_in = '0;
            used_in  = 1'b0;
            len_in   = (INDEX == 0) ? cmd_len : '0;
         end
         CMD_WRITE: begin
            if (MY_IDX == cmd_idx) begin
               len_in  = cmd_len;
               used_in = cmd.used;
            end
         end
         CMD_INSERT: begin
            if (MY_IDX > cmd_idx) begin
               start_in = left_start;
               len_in   = left_len;
               used_in  = left_used;
            end else if (MY_IDX == cmd_idx) begin
               start_in = cmd_start;
               len_in   = cmd_len;
               used_in  = cmd.used;
            end
         end
         CMD_REMOVE: begin
            if (MY_IDX >= cmd_idx) begin
               start_in = right_start;
               len_in   = right_len;
               used_in  = right_used;
            end
         end
         default: ;
      endcase
   end

   // Search token update as it passes this entry.
   always_comb begin
      tctl_in   = tok_in;
      tidx_in   = tok_in_idx;
      tlen_in   = tok_in_len;
      tstart_in = tok_in_start;
      tprev_in  = tok_in_prev_len;
      tnext_in  = tok_in_next_len;
      tcnt_in   = tok_in_cnt;
      unique case (op)
         OP_ALLOC: begin
            if (fits && (!tok_in.found || better)) begin
               tctl_in.found = 1'b1;
               tidx_in       = MY_IDX;
               tlen_in       = len_ff;
               tstart_in     = start_ff;
            end
         end
         OP_FREE: begin
            if (!tok_in.found && live && (CW'(start_ff) == CW'(baddr))) begin
               tctl_in.found     = 1'b1;
               tctl_in.used_i    = used_ff;
               tctl_in.has_prev  = (INDEX > 0);
               tctl_in.prev_used = left_used;
               tctl_in.has_next  = NX_POS < total;
               tctl_in.next_used = right_used;
               tidx_in           = MY_IDX;
               tlen_in           = len_ff;
               tprev_in          = left_len;
               tnext_in          = right_len;
            end
         end
         OP_COUNT: begin
            if (live && !used_ff && (len_x < CW'(limit))) begin
               tcnt_in = tok_in_cnt + CNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         len_ff   <= (INDEX == 0) ? ADDR_BITS'(RESET_POOL) : '0;
         used_ff  <= 1'b0;
         tctl_ff  <= '0;
      end else begin
         start_ff <= start_in;
         len_ff   <= len_in;
         used_ff  <= used_in;
         tctl_ff  <= tctl_in;
      end
   end

   always_ff @(posedge clock) begin
      tidx_ff   <= tidx_in;
      tlen_ff   <= tlen_in;
      tstart_ff <= tstart_in;
      tprev_ff  <= tprev_in;
      tnext_ff  <= tnext_in;
      tcnt_ff   <= tcnt_in;
   end

   assign seg_start        = start_ff;
   assign seg_len          = len_ff;
   assign seg_used         = used_ff;
   assign tok_out          = tctl_ff;
   assign tok_out_idx      = tidx_ff;
   assign tok_out_len      = tlen_ff;
   assign tok_out_start    = tstart_ff;
   assign tok_out_prev_len = tprev_ff;
   assign tok_out_next_len = tnext_ff;
   assign tok_out_cnt      = tcnt_ff;

endmodule

@@ rtl/fit_segment_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_segment_allocator: best-fit / worst-fit segment pool allocator
//
// Requests arrive on the req_ stream (allocate, free or count small free
// segments); each yields exactly one transfer on the rsp_ stream. The segment
// table is a row of MAX_SEGMENTS cells. A search token walks the row one cell
// per cycle; then up to three table commands (write, insert with shift,
// remove with shift) are applied in turn in the apply state, and the result is
// loaded into the output register. The next request can be taken once the
// result is loaded, so there is one item in work at a time.
// req_tready is high only while the sequencer is idle; the output register
// holds a finished result while rsp_tready is low, and the next request can
// be accepted during that wait.
// The csr_ port is always ready; a pool_size write reloads the table to one
// free segment. Reset gives best fit, a 65535-byte pool, 32 header bytes and
// an empty output register.
// ----------------------------------------------------------------------------
module fit_segment_allocator #(
   parameter int MAX_SEGMENTS = fsa_pkg::MAX_SEGMENTS_DEF,
   parameter int ADDR_BITS    = fsa_pkg::ADDR_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // op [1:0], request_size [17:2], block_address [33:18], zero fill above
   input  logic [fsa_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status [1:0], granted_address [17:2], small_free_count [24:18], zero fill
   output logic [fsa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fsa_pkg::CSR_DAT_W-1:0]    csr_data
);
   import fsa_pkg::*;

   localparam int IW    = $clog2(MAX_SEGMENTS);
   localparam int TW    = $clog2(MAX_SEGMENTS + 1);
   localparam int CW    = (ADDR_BITS > NEED_W) ? ADDR_BITS : NEED_W;
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam logic [TW-1:0] TOTAL_MAX = TW'(MAX_SEGMENTS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY,
      S_OUT
   } state_type;

   state_type state_ff;
   logic [TW-1:0]    total_ff;
   logic             mode_ff;
   logic [HDR_W-1:0] header_ff;
   op_type           op_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [BADDR_W-1:0] baddr_ff;
   logic [NEED_W-1:0]  need_ff;
   logic               inject_ff;
   logic [1:0]         step_ff;

   cmd_ctl_type          cmdc_ff [3];
   logic [IW-1:0]        cmdi_ff [3];
   logic [ADDR_BITS-1:0] cmds_ff [3];
   logic [ADDR_BITS-1:0] cmdl_ff [3];
   cmd_ctl_type          cmdc_in [3];
   logic [IW-1:0]        cmdi_in [3];
   logic [ADDR_BITS-1:0] cmds_in [3];
   logic [ADDR_BITS-1:0] cmdl_in [3];

   status_type         res_status_ff, res_status_in;
   logic [GRANT_W-1:0] res_addr_ff, res_addr_in;
   logic [COUNT_W-1:0] res_cnt_ff, res_cnt_in;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [GRANT_W-1:0] rsp_addr_ff;
   logic [COUNT_W-1:0] rsp_cnt_ff;

   cmd_ctl_type          cmd;
   logic [IW-1:0]        cmd_idx;
   logic [ADDR_BITS-1:0] cmd_start;
   logic [ADDR_BITS-1:0] cmd_len;

   logic [ADDR_BITS-1:0] c_start [MAX_SEGMENTS];
   logic [ADDR_BITS-1:0] c_len   [MAX_SEGMENTS];
   logic                 c_used  [MAX_SEGMENTS];
   tok_ctl_type          t_ctl   [MAX_SEGMENTS];
   logic [IW-1:0]        t_idx   [MAX_SEGMENTS];
   logic [ADDR_BITS-1:0] t_len   [MAX_SEGMENTS];
   logic [ADDR_BITS-1:0] t_start [MAX_SEGMENTS];
   logic [ADDR_BITS-1:0] t_prev  [MAX_SEGMENTS];
   logic [ADDR_BITS-1:0] t_next  [MAX_SEGMENTS];
   logic [CNT_W-1:0]     t_cnt   [MAX_SEGMENTS];

   tok_ctl_type tok0;
   tok_ctl_type tk;
   logic        req_fire;
   logic        csr_fire;
   logic        load_rsp;
   logic [SIZE_W:0]  rounded;
   logic [NEED_W-1:0] need_in;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign load_rsp   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   assign rounded = ({1'b0, req_tdata[17:2]} + (SIZE_W+1)'(3)) & ~(SIZE_W+1)'(3);
   assign need_in = NEED_W'(rounded) + NEED_W'(header_ff);

   always_comb begin
      tok0       = '0;
      tok0.valid = inject_ff;
   end

   // Broadcast command to the cells.
   always_comb begin
      cmd       = '{kind: CMD_NONE, used: 1'b0};
      cmd_idx   = '0;
      cmd_start = '0;
      cmd_len   = '0;
      if (csr_fire && (csr_index == CSR_POOL)) begin
         cmd.kind = CMD_INIT;
         cmd_len  = ADDR_BITS'(csr_data);
      end else if (state_ff == S_APPLY) begin
         cmd       = cmdc_ff[step_ff];
         cmd_idx   = cmdi_ff[step_ff];
         cmd_start = cmds_ff[step_ff];
         cmd_len   = cmdl_ff[step_ff];
      end
   end

   genvar g;
   generate
      for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
         logic [ADDR_BITS-1:0] ls, ll, rs, rl;
         logic                 lu, ru;
         tok_ctl_type          ti;
         logic [IW-1:0]        tidx;
         logic [ADDR_BITS-1:0] tlen, tst, tpv, tnx;
         logic [CNT_W-1:0]     tcnt;
         if (g == 0) begin : g_first
            assign ls = '0;
            assign ll = '0;
            assign lu = 1'b0;
            assign ti = tok0;
            assign tidx = '0;
            assign tlen = '0;
            assign tst  = '0;
            assign tpv  = '0;
            assign tnx  = '0;
            assign tcnt = '0;
         end else begin : g_rest
            assign ls = c_start[g-1];
            assign ll = c_len[g-1];
            assign lu = c_used[g-1];
            assign ti = t_ctl[g-1];
            assign tidx = t_idx[g-1];
            assign tlen = t_len[g-1];
            assign tst  = t_start[g-1];
            assign tpv  = t_prev[g-1];
            assign tnx  = t_next[g-1];
            assign tcnt = t_cnt[g-1];
         end
         if (g == MAX_SEGMENTS - 1) begin : g_last
            assign rs = '0;
            assign rl = '0;
            assign ru = 1'b0;
         end else begin : g_mid
            assign rs = c_start[g+1];
            assign rl = c_len[g+1];
            assign ru = c_used[g+1];
         end
         fsa_cell #(
            .INDEX(g), .ADDR_BITS(ADDR_BITS), .IW(IW), .TW(TW), .CW(CW), .CNT_W(CNT_W)
         ) u_cell (
            .clock(clock), .reset(reset), .total(total_ff), .op(op_ff),
            .fit_mode(mode_ff), .need(need_ff), .limit(size_ff), .baddr(baddr_ff),
            .cmd(cmd), .cmd_idx(cmd_idx), .cmd_start(cmd_start), .cmd_len(cmd_len),
            .left_start(ls), .left_len(ll), .left_used(lu),
            .right_start(rs), .right_len(rl), .right_used(ru),
            .seg_start(c_start[g]), .seg_len(c_len[g]), .seg_used(c_used[g]),
            .tok_in(ti), .tok_in_idx(tidx), .tok_in_len(tlen), .tok_in_start(tst),
            .tok_in_prev_len(tpv), .tok_in_next_len(tnx), .tok_in_cnt(tcnt),
            .tok_out(t_ctl[g]), .tok_out_idx(t_idx[g]), .tok_out_len(t_len[g]),
            .tok_out_start(t_start[g]), .tok_out_prev_len(t_prev[g]),
            .tok_out_next_len(t_next[g]), .tok_out_cnt(t_cnt[g])
         );
      end
   endgenerate

   assign tk = t_ctl[MAX_SEGMENTS-1];

   // Decision from the token that has left the last cell.
   always_comb begin
      logic [ADDR_BITS-1:0] blen, bstart, lp, ln;
      logic [IW-1:0]        bidx;
      logic [CW-1:0]        rem;
      logic [CW-1:0]        sum_next, sum_all, new_start;
      logic [31:0]          cnt_w;
      logic                 prev_free, next_free;
      blen      = t_len[MAX_SEGMENTS-1];
      bstart    = t_start[MAX_SEGMENTS-1];
      lp        = t_prev[MAX_SEGMENTS-1];
      ln        = t_next[MAX_SEGMENTS-1];
      bidx      = t_idx[MAX_SEGMENTS-1];
      rem       = CW'(blen) - CW'(need_ff);
      new_start = CW'(bstart) + CW'(need_ff);
      sum_next  = CW'(blen) + CW'(ln);
      sum_all   = sum_next + CW'(lp);
      cnt_w     = 32'(t_cnt[MAX_SEGMENTS-1]);
      prev_free = tk.has_prev && !tk.prev_used;
      next_free = tk.has_next && !tk.next_used;
      for (int k = 0; k < 3; k++) begin
         cmdc_in[k] = '{kind: CMD_NONE, used: 1'b0};
         cmdi_in[k] = '0;
         cmds_in[k] = '0;
         cmdl_in[k] = '0;
      end
      res_status_in = ST_OK;
      res_addr_in   = '0;
      res_cnt_in    = '0;
      unique case (op_ff)
         OP_ALLOC: begin
            if ((size_ff == '0) || !tk.found) begin
               res_status_in = ST_NO_MEMORY;
            end else begin
               res_addr_in = GRANT_W'(bstart);
               cmdc_in[0]  = '{kind: CMD_WRITE, used: 1'b1};
               cmdi_in[0]  = bidx;
               if ((rem > CW'(header_ff)) && (total_ff < TOTAL_MAX)) begin
                  cmdl_in[0] = ADDR_BITS'(need_ff);
                  cmdc_in[1] = '{kind: CMD_INSERT, used: 1'b0};
                  cmdi_in[1] = bidx + IW'(1);
                  cmds_in[1] = ADDR_BITS'(new_start);
                  cmdl_in[1] = ADDR_BITS'(rem);
               end else begin
                  cmdl_in[0] = blen;
               end
            end
         end
         OP_FREE: begin
            if (!tk.found) begin
               res_status_in = ST_NOT_FOUND;
            end else if (!tk.used_i) begin
               res_status_in = ST_FREED;
            end else if (prev_free && next_free) begin
               cmdc_in[0] = '{kind: CMD_WRITE, used: 1'b0};
               cmdi_in[0] = bidx - IW'(1);
               cmdl_in[0] = ADDR_BITS'(sum_all);
               cmdc_in[1] = '{kind: CMD_REMOVE, used: 1'b0};
               cmdi_in[1] = bidx;
               cmdc_in[2] = '{kind: CMD_REMOVE, used: 1'b0};
               cmdi_in[2] = bidx;
            end else if (next_free) begin
               cmdc_in[0] = '{kind: CMD_WRITE, used: 1'b0};
               cmdi_in[0] = bidx;
               cmdl_in[0] = ADDR_BITS'(sum_next);
               cmdc_in[1] = '{kind: CMD_REMOVE, used: 1'b0};
               cmdi_in[1] = bidx + IW'(1);
            end else if (prev_free) begin
               cmdc_in[0] = '{kind: CMD_WRITE, used: 1'b0};
               cmdi_in[0] = bidx - IW'(1);
               cmdl_in[0] = ADDR_BITS'(CW'(lp) + CW'(blen));
               cmdc_in[1] = '{kind: CMD_REMOVE, used: 1'b0};
               cmdi_in[1] = bidx;
            end else begin
               cmdc_in[0] = '{kind: CMD_WRITE, used: 1'b0};
               cmdi_in[0] = bidx;
               cmdl_in[0] = blen;
            end
         end
         OP_COUNT: begin
            res_cnt_in = (cnt_w > 32'(COUNT_MAX)) ? COUNT_MAX : cnt_w[COUNT_W-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= TW'(1);
         mode_ff      <= 1'b0;
         header_ff    <= RESET_HEADER;
         inject_ff    <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            cmdc_ff[k] <= '{kind: CMD_NONE, used: 1'b0};
         end
      end else begin
         // The token enters the first cell right after a request transfer.
         inject_ff <= req_fire;
         if (csr_fire) begin
            if (csr_index == CSR_FIT_MODE) begin
               mode_ff <= csr_data[0];
            end else if (csr_index == CSR_HEADER) begin
               header_ff <= csr_data[HDR_W-1:0];
            end
         end
         if (cmd.kind == CMD_INIT) begin
            total_ff <= TW'(1);
         end else if (cmd.kind == CMD_INSERT) begin
            total_ff <= total_ff + TW'(1);
         end else if (cmd.kind == CMD_REMOVE) begin
            total_ff <= total_ff - TW'(1);
         end
         if (rsp_tready && !load_rsp) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  state_ff  <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (tk.valid) begin
                  for (int k = 0; k < 3; k++) begin
                     cmdc_ff[k] <= cmdc_in[k];
                  end
                  step_ff  <= '0;
                  state_ff <= S_APPLY;
               end
            end
            S_APPLY: begin
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd2) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (load_rsp) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= op_type'(req_tdata[1:0]);
         size_ff  <= req_tdata[17:2];
         baddr_ff <= req_tdata[33:18];
         need_ff  <= need_in;
      end
      if ((state_ff == S_SCAN) && tk.valid) begin
         for (int k = 0; k < 3; k++) begin
            cmdi_ff[k] <= cmdi_in[k];
            cmds_ff[k] <= cmds_in[k];
            cmdl_ff[k] <= cmdl_in[k];
         end
         res_status_ff <= res_status_in;
         res_addr_ff   <= res_addr_in;
         res_cnt_ff    <= res_cnt_in;
      end
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_cnt_ff    <= res_cnt_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_cnt_ff, rsp_addr_ff, rsp_status_ff};

endmodule

@@ tb/fit_segment_allocator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_segment_allocator_test: self-checking bench for the segment allocator
// Drives allocate, free and count requests through the req_ stream, keeps its
// own copy of the segment table to predict every response, and compares each
// rsp_ transfer field by field. The run goes through several register
// settings and several mixes of sender idle cycles and receiver stalls.
// ----------------------------------------------------------------------------
module fit_segment_allocator_test;
   import fsa_pkg::*;

   localparam int SEGS = 64;

   typedef struct {
      op_type      op;
      logic [15:0] size;
      logic [15:0] addr;
   } request_type;

   typedef struct {
      status_type  status;
      logic [15:0] grant;
      logic [6:0]  count;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   fit_segment_allocator uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the segment table and registers.
   logic [15:0] shadow_start [SEGS];
   logic [15:0] shadow_length [SEGS];
   bit          shadow_used [SEGS];
   int          shadow_total;
   bit          shadow_worst;
   logic [15:0] shadow_pool;
   int          shadow_header;

   request_type  pending_requests[$];
   response_type awaited_responses[$];
   logic [15:0]  live_grants[$];
   int  error_count = 0;
   int  idle_pct = 0;
   int  stall_pct = 0;
   bit  req_taken = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic void table_reload();
      for (int i = 0; i < SEGS; i++) begin
         shadow_start[i] = '0;
         shadow_length[i] = '0;
         shadow_used[i] = 0;
      end
      shadow_length[0] = shadow_pool;
      shadow_total = 1;
   endfunction

   function automatic void table_delete(int k);
      for (int i = k; i + 1 < shadow_total; i++) begin
         shadow_start[i] = shadow_start[i+1];
         shadow_length[i] = shadow_length[i+1];
         shadow_used[i] = shadow_used[i+1];
      end
      shadow_total--;
      shadow_start[shadow_total] = '0;
      shadow_length[shadow_total] = '0;
      shadow_used[shadow_total] = 0;
   endfunction

   function automatic response_type allocator_outcome(request_type it);
      response_type r;
      int need, pick, rest;
      bit found;
      r.status = ST_OK;
      r.grant = '0;
      r.count = '0;
      found = 0;
      pick = 0;
      case (it.op)
         OP_ALLOC: begin
            if (it.size == 0) begin
               r.status = ST_NO_MEMORY;
            end else begin
               need = ((int'(it.size) + 3) & ~3) + shadow_header;
               for (int i = 0; i < shadow_total; i++) begin
                  if (shadow_used[i] || int'(shadow_length[i]) < need) continue;
                  if (!found) begin
                     found = 1;
                     pick = i;
                  end else if (shadow_worst ? shadow_length[i] > shadow_length[pick]
                                            : shadow_length[i] < shadow_length[pick]) begin
                     pick = i;
                  end
               end
               if (!found) begin
                  r.status = ST_NO_MEMORY;
               end else begin
                  rest = int'(shadow_length[pick]) - need;
                  if (rest > shadow_header && shadow_total < SEGS) begin
                     for (int i = shadow_total; i > pick + 1; i--) begin
                        shadow_start[i] = shadow_start[i-1];
                        shadow_length[i] = shadow_length[i-1];
                        shadow_used[i] = shadow_used[i-1];
                     end
                     shadow_start[pick+1] = shadow_start[pick] + need[15:0];
                     shadow_length[pick+1] = rest[15:0];
                     shadow_used[pick+1] = 0;
                     shadow_length[pick] = need[15:0];
                     shadow_total++;
                  end
                  shadow_used[pick] = 1;
                  r.grant = shadow_start[pick];
                  live_grants.push_back(r.grant);
               end
            end
         end
         OP_FREE: begin
            r.status = ST_NOT_FOUND;
            for (int i = 0; i < shadow_total; i++) begin
               if (shadow_start[i] != it.addr) continue;
               if (!shadow_used[i]) begin
                  r.status = ST_FREED;
               end else begin
                  r.status = ST_OK;
                  shadow_used[i] = 0;
                  if (i + 1 < shadow_total && !shadow_used[i+1]) begin
                     shadow_length[i] = shadow_length[i] + shadow_length[i+1];
                     table_delete(i + 1);
                  end
                  if (i > 0 && !shadow_used[i-1]) begin
                     shadow_length[i-1] = shadow_length[i-1] + shadow_length[i];
                     table_delete(i);
                  end
               end
               break;
            end
         end
         OP_COUNT: begin
            for (int i = 0; i < shadow_total; i++)
               if (!shadow_used[i] && shadow_length[i] < it.size) r.count++;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Driver: inputs change on the falling edge only.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
         if (!req_tvalid || req_taken) begin
            req_taken = 0;
            if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= {6'b0, pending_requests[0].addr, pending_requests[0].size,
                             pending_requests[0].op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: predict on each request transfer, check each response transfer.
   always @(posedge clock) begin
      response_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            awaited_responses.push_back(allocator_outcome(pending_requests.pop_front()));
            req_taken = 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_responses.size() == 0) begin
               report_mismatch("unexpected response", int'(rsp_tdata), 0);
            end else begin
               want = awaited_responses.pop_front();
               if (rsp_tdata[1:0] != want.status)
                  report_mismatch("status", rsp_tdata[1:0], want.status);
               if (rsp_tdata[17:2] != want.grant)
                  report_mismatch("granted_address", rsp_tdata[17:2], want.grant);
               if (rsp_tdata[24:18] != want.count)
                  report_mismatch("small_free_count", rsp_tdata[24:18], want.count);
            end
         end
      end
   end

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[15:0];
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FIT_MODE: shadow_worst = value[0];
         CSR_POOL: begin
            shadow_pool = value[15:0];
            table_reload();
            live_grants.delete();
         end
         default: shadow_header = value[7:0];
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic push_request(input op_type op, input int size, input int addr);
      request_type it;
      it.op = op;
      it.size = size[15:0];
      it.addr = addr[15:0];
      pending_requests.push_back(it);
   endtask

   task automatic drain_block();
      wait (pending_requests.size() == 0 && awaited_responses.size() == 0);
      repeat (100) @(posedge clock);
   endtask

   // Mostly well-formed traffic: frees target live grants, sizes stay small.
   task automatic random_traffic(input int items);
      int pick, k;
      for (int n = 0; n < items; n++) begin
         while (pending_requests.size() > 1) @(posedge clock);
         pick = $urandom_range(99);
         if (pick < 50) begin
            push_request(OP_ALLOC, ($urandom_range(19) == 0) ? $urandom_range(65535)
                                   : $urandom_range(400), $urandom_range(65535));
         end else if (pick < 80) begin
            if (live_grants.size() > 0 && $urandom_range(9) != 0) begin
               k = $urandom_range(live_grants.size() - 1);
               push_request(OP_FREE, $urandom_range(65535), live_grants[k]);
               live_grants.delete(k);
            end else begin
               push_request(OP_FREE, $urandom_range(65535), $urandom_range(65535));
            end
         end else if (pick < 95) begin
            push_request(OP_COUNT, ($urandom_range(3) == 0) ? $urandom_range(65535)
                                   : $urandom_range(600), $urandom_range(65535));
         end else begin
            push_request(OP_NOP, $urandom_range(65535), $urandom_range(65535));
         end
      end
      drain_block();
   endtask

   initial begin
      shadow_worst = 0;
      shadow_pool = RESET_POOL;
      shadow_header = RESET_HEADER;
      table_reload();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part on reset settings: zero request, oversize request,
      // splits, whole grant, bad and double frees, merges, count limits.
      push_request(OP_ALLOC, 0, 0);
      push_request(OP_ALLOC, 1, 0);
      push_request(OP_ALLOC, 65535, 0);
      push_request(OP_ALLOC, 100, 0);
      push_request(OP_ALLOC, 100, 0);
      push_request(OP_ALLOC, 200, 0);
      push_request(OP_FREE, 0, 36);
      push_request(OP_FREE, 0, 36);
      push_request(OP_FREE, 0, 37);
      push_request(OP_COUNT, 65535, 0);
      push_request(OP_FREE, 0, 168);
      push_request(OP_COUNT, 0, 0);
      push_request(OP_NOP, 65535, 65535);
      push_request(OP_FREE, 65535, 0);
      push_request(OP_FREE, 0, 300);
      push_request(OP_ALLOC, 65500, 0);
      push_request(OP_COUNT, 1, 0);
      push_request(OP_FREE, 0, 0);
      push_request(OP_COUNT, 65535, 65535);
      drain_block();

      write_register(CSR_FIT_MODE, 1);
      write_register(CSR_HEADER, 0);
      write_register(CSR_POOL, 260);
      idle_pct = 52;
      random_traffic(100);

      write_register(CSR_FIT_MODE, 0);
      write_register(CSR_HEADER, 255);
      write_register(CSR_POOL, 65535);
      idle_pct = 0;
      stall_pct = 52;
      random_traffic(110);

      write_register(CSR_FIT_MODE, 1);
      write_register(CSR_HEADER, 8);
      write_register(CSR_POOL, 5000);
      idle_pct = 7;
      stall_pct = 7;
      random_traffic(110);

      write_register(CSR_FIT_MODE, 0);
      write_register(CSR_HEADER, 32);
      write_register(CSR_POOL, 40000);
      idle_pct = 0;
      stall_pct = 0;
      random_traffic(110);

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
